### src/swcd_pkg.sv
`timescale 1ns / 1ps
// swcd_pkg: shared widths, constants and types of the status word change detector
// no dependencies

package swcd_pkg;

  localparam int unsigned WORD_W      = 16;
  localparam int unsigned POINT_W     = 8;
  localparam int unsigned PAIR_W      = 7;
  localparam int unsigned SLOT_OUT_W  = 8;

  localparam int unsigned STORE_WORDS = 256;
  localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
  localparam int unsigned RING_SLOTS  = 256;
  localparam int unsigned SLOT_W      = $clog2(RING_SLOTS);

  typedef struct packed {
    logic [POINT_W-1:0] point_word;
    logic [WORD_W-1:0]  new_word;
    logic               last_in_burst;
  } item_t;

  typedef struct packed {
    logic [PAIR_W-1:0]     pair_offset;
    logic [WORD_W-1:0]     even_word;
    logic [WORD_W-1:0]     odd_word;
    logic [WORD_W-1:0]     even_change;
    logic [WORD_W-1:0]     odd_change;
    logic [SLOT_OUT_W-1:0] record_slot;
  } rec_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } wr_req_t;

endpackage

### src/swcd_in_if.sv
`timescale 1ns / 1ps
// swcd_in_if: status word input channel, valid/ready with payload
// depends on swcd_pkg

interface swcd_in_if;
  logic                          valid;
  logic                          ready;
  logic [swcd_pkg::POINT_W-1:0]  point_word;
  logic [swcd_pkg::WORD_W-1:0]   new_word;
  logic                          last_in_burst;

  modport source (output valid, output point_word, output new_word,
                  output last_in_burst, input ready);
  modport sink   (input valid, input point_word, input new_word,
                  input last_in_burst, output ready);
endinterface

### src/swcd_cfg_if.sv
`timescale 1ns / 1ps
// swcd_cfg_if: configuration write channel for the report_changes register
// no dependencies

interface swcd_cfg_if;
  logic valid;
  logic ready;
  logic report_changes;

  modport source (output valid, output report_changes, input ready);
  modport sink   (input valid, input report_changes, output ready);
endinterface

### src/swcd_out_if.sv
`timescale 1ns / 1ps
// swcd_out_if: change record output channel, valid/ready with payload
// depends on swcd_pkg

interface swcd_out_if;
  logic                            valid;
  logic                            ready;
  logic [swcd_pkg::PAIR_W-1:0]     pair_offset;
  logic [swcd_pkg::WORD_W-1:0]     even_word;
  logic [swcd_pkg::WORD_W-1:0]     odd_word;
  logic [swcd_pkg::WORD_W-1:0]     even_change;
  logic [swcd_pkg::WORD_W-1:0]     odd_change;
  logic [swcd_pkg::SLOT_OUT_W-1:0] record_slot;

  modport source (output valid, output pair_offset, output even_word, output odd_word,
                  output even_change, output odd_change, output record_slot,
                  input ready);
  modport sink   (input valid, input pair_offset, input even_word, input odd_word,
                  input even_change, input odd_change, input record_slot,
                  output ready);
endinterface

### src/swcd_store.sv
`timescale 1ns / 1ps
// swcd_store: status word memory, two registered read ports, one write port,
// per-entry valid bits and forwarding of the latest write; depends on swcd_pkg

module swcd_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  swcd_pkg::rd_req_t            rd_i,
  input  swcd_pkg::wr_req_t            wr_i,
  output logic [swcd_pkg::WORD_W-1:0]  old_word_o,
  output logic [swcd_pkg::WORD_W-1:0]  partner_word_o
);

  logic [swcd_pkg::WORD_W-1:0]      mem_q [swcd_pkg::STORE_WORDS];
  logic [swcd_pkg::STORE_WORDS-1:0] vld_q;

  logic [swcd_pkg::WORD_W-1:0] rd_a_q, rd_b_q;
  logic                        vld_a_q, vld_b_q;
  logic [swcd_pkg::ADDR_W-1:0] addr_q;

  logic                        lw_vld_q;
  logic [swcd_pkg::ADDR_W-1:0] lw_addr_q;
  logic [swcd_pkg::WORD_W-1:0] lw_data_q;

  logic [swcd_pkg::ADDR_W-1:0] partner_addr, partner_q;

  assign partner_addr = rd_i.addr ^ swcd_pkg::ADDR_W'(1);
  assign partner_q    = addr_q ^ swcd_pkg::ADDR_W'(1);

  // memory array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_a_q <= mem_q[rd_i.addr];
      rd_b_q <= mem_q[partner_addr];
    end
  end

  // valid bits stand in for the clear at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      addr_q    <= '0;
      lw_vld_q  <= 1'b0;
      lw_addr_q <= '0;
      lw_data_q <= '0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
        lw_vld_q         <= 1'b1;
        lw_addr_q        <= wr_i.addr;
        lw_data_q        <= wr_i.data;
      end
      if (rd_i.en) begin
        vld_a_q <= vld_q[rd_i.addr];
        vld_b_q <= vld_q[partner_addr];
        addr_q  <= rd_i.addr;
      end
    end
  end

  // the write on the read edge is missed by the array read: forward it
  always_comb begin
    if (lw_vld_q && (lw_addr_q == addr_q)) begin
      old_word_o = lw_data_q;
    end else begin
      old_word_o = vld_a_q ? rd_a_q : '0;
    end
    if (lw_vld_q && (lw_addr_q == partner_q)) begin
      partner_word_o = lw_data_q;
    end else begin
      partner_word_o = vld_b_q ? rd_b_q : '0;
    end
  end

endmodule

### src/swcd_pair.sv
`timescale 1ns / 1ps
// swcd_pair: change masks, even/odd pairing with pending even word, slot counter
// depends on swcd_pkg

module swcd_pair (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic                         report_i,
  input  swcd_pkg::item_t              item_i,
  input  logic [swcd_pkg::WORD_W-1:0]  old_word_i,
  input  logic [swcd_pkg::WORD_W-1:0]  partner_word_i,
  output logic                         emit_o,
  output swcd_pkg::rec_t               rec_o
);

  logic                          pend_vld_q, pend_vld_d;
  logic [swcd_pkg::WORD_W-1:0]   pend_chg_q, pend_chg_d;
  logic [swcd_pkg::PAIR_W-1:0]   pend_pair_q, pend_pair_d;
  logic [swcd_pkg::SLOT_W-1:0]   slot_q, slot_d;

  logic [swcd_pkg::WORD_W-1:0]   chg, evc;
  logic [swcd_pkg::PAIR_W-1:0]   pair;

  assign chg  = item_i.new_word ^ old_word_i;
  assign pair = item_i.point_word[swcd_pkg::POINT_W-1:1];

  always_comb begin
    pend_vld_d  = 1'b0;
    pend_chg_d  = '0;
    pend_pair_d = pend_pair_q;
    emit_o      = 1'b0;
    evc         = (pend_vld_q && (pend_pair_q == pair)) ? pend_chg_q : '0;

    rec_o.pair_offset = pair;
    rec_o.record_slot = swcd_pkg::SLOT_OUT_W'(slot_q);
    if (item_i.point_word[0]) begin
      rec_o.even_word   = partner_word_i;
      rec_o.odd_word    = item_i.new_word;
      rec_o.even_change = evc;
      rec_o.odd_change  = chg;
    end else begin
      rec_o.even_word   = item_i.new_word;
      rec_o.odd_word    = partner_word_i;
      rec_o.even_change = chg;
      rec_o.odd_change  = '0;
    end

    if (report_i) begin
      if (item_i.point_word[0]) begin
        emit_o = ((evc | chg) != '0);
      end else if (!item_i.last_in_burst) begin
        // hold the even word until its odd partner turns up
        pend_vld_d  = 1'b1;
        pend_chg_d  = chg;
        pend_pair_d = pair;
      end else begin
        emit_o = (chg != '0);
      end
    end

    if (emit_o) begin
      slot_d = (slot_q == swcd_pkg::SLOT_W'(swcd_pkg::RING_SLOTS - 1)) ? '0 :
               slot_q + swcd_pkg::SLOT_W'(1);
    end else begin
      slot_d = slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q  <= 1'b0;
      pend_chg_q  <= '0;
      pend_pair_q <= '0;
      slot_q      <= '0;
    end else if (fire_i) begin
      pend_vld_q  <= pend_vld_d;
      pend_chg_q  <= pend_chg_d;
      pend_pair_q <= pend_pair_d;
      slot_q      <= slot_d;
    end
  end

endmodule

### src/status_word_change_detector_unit.sv
`timescale 1ns / 1ps
// throughput: one status word per cycle unless a held output record stalls stage one, set by
//   the store read-modify-write (read at transfer into stage one, modify and write back as
//   the item leaves it, its record then held in the output register, latest write forwarded
//   to the following read); reset: store entries read as zero through per-entry valid bits
//   cleared at once, no clearing pass; pending word dropped, slot number 0, report_changes 1

module status_word_change_detector_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  swcd_in_if.sink     in_i,
  swcd_cfg_if.sink    cfg_i,
  swcd_out_if.source  out_o
);

  // configuration register, always ready
  logic report_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_q <= 1'b1;
    end else if (cfg_i.valid) begin
      report_q <= cfg_i.report_changes;
    end
  end

  // stage one: item whose store words are being read
  logic            s1_vld_q;
  swcd_pkg::item_t s1_item_q;
  logic            in_ready, accept, fire, out_blocked;

  // output register
  logic            out_vld_q, out_vld_d;
  swcd_pkg::rec_t  out_rec_q;

  logic            emit;
  swcd_pkg::rec_t  rec;

  assign out_blocked = out_vld_q && !out_o.ready;
  assign fire        = s1_vld_q && !out_blocked;
  assign in_ready    = !s1_vld_q || fire;
  assign accept      = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.point_word    <= in_i.point_word;
      s1_item_q.new_word      <= in_i.new_word;
      s1_item_q.last_in_burst <= in_i.last_in_burst;
    end
  end

  // store: read at transfer, write back when the item leaves stage one
  swcd_pkg::rd_req_t           rd_req;
  swcd_pkg::wr_req_t           wr_req;
  logic [swcd_pkg::WORD_W-1:0] old_word, partner_word;

  assign rd_req.en   = accept;
  assign rd_req.addr = swcd_pkg::ADDR_W'(in_i.point_word);
  assign wr_req.en   = fire;
  assign wr_req.addr = swcd_pkg::ADDR_W'(s1_item_q.point_word);
  assign wr_req.data = s1_item_q.new_word;

  swcd_store u_store (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_i           (rd_req),
    .wr_i           (wr_req),
    .old_word_o     (old_word),
    .partner_word_o (partner_word)
  );

  swcd_pair u_pair (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .report_i       (report_q),
    .item_i         (s1_item_q),
    .old_word_i     (old_word),
    .partner_word_i (partner_word),
    .emit_o         (emit),
    .rec_o          (rec)
  );

  // output register takes a new record while the old one is transferred
  always_comb begin
    if (fire && emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_rec_q <= rec;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.pair_offset = out_rec_q.pair_offset;
  assign out_o.even_word   = out_rec_q.even_word;
  assign out_o.odd_word    = out_rec_q.odd_word;
  assign out_o.even_change = out_rec_q.even_change;
  assign out_o.odd_change  = out_rec_q.odd_change;
  assign out_o.record_slot = out_rec_q.record_slot;

`ifndef SYNTHESIS
  // a stalled stage one must not be overwritten by a new transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_blocked) |-> !in_ready)
    else $error("input taken while stage one is stalled");

  // a record produced in stage one shows at the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> out_o.valid)
    else $error("change record lost");

  // a held record keeps its slot number until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_blocked && !fire) |=> $stable(out_rec_q.record_slot))
    else $error("record slot changed while stalled");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for status_word_change_detector_unit, directed table then
// random bursts with random idling on both channels, records checked against a local predictor
// depends on swcd_pkg, swcd_in_if, swcd_cfg_if, swcd_out_if and the unit itself

module testbench;
  import swcd_pkg::*;

  // timing of the checks
  localparam int SETTLE_CYCLES = 4;     // margin after the last due record for words still in flight
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the pipeline
  localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
  localparam int MAX_REPORTS   = 10;

  // random phases: register setting, word count, calm links, one phase with hold-off
  localparam int PHASES     = 6;
  localparam int HOLD_PHASE = 2;
  localparam bit PHASE_REPORT [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam bit PHASE_CALM   [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam int PHASE_ITEMS  [PHASES] = '{350, 120, 350, 300, 120, 400};

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  // one line of stimulus: a status word transfer or a register write; where typed is set,
  // hit and rec are the expected outcome, otherwise the predictor decides
  typedef struct packed {
    row_kind_e          kind;
    logic [POINT_W-1:0] point;
    logic [WORD_W-1:0]  word;
    logic               last;
    logic               report;
    logic               typed;
    logic               hit;
    rec_t               rec;
  } stim_row_t;

  // after reset: store all zero, slot 0, reporting on
  localparam stim_row_t DIRECTED_ROWS [27] = '{
    // odd word with no partner, all bits set
    '{ROW_WORD, 8'h01, 16'hffff, 1'b0, 1'b0, 1'b1, 1'b1,
      '{7'h00, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 8'h00}},
    // full pair, both words changed
    '{ROW_WORD, 8'h00, 16'h5555, 1'b0, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_WORD, 8'h01, 16'haaaa, 1'b1, 1'b0, 1'b1, 1'b1,
      '{7'h00, 16'h5555, 16'haaaa, 16'h5555, 16'h5555, 8'h01}},
    // even word ends a burst in the top pair of the store
    '{ROW_WORD, 8'hfe, 16'hffff, 1'b1, 1'b0, 1'b1, 1'b1,
      '{7'h7f, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 8'h02}},
    // odd word unchanged, nothing to say
    '{ROW_WORD, 8'hff, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_WORD, 8'hff, 16'hffff, 1'b0, 1'b0, 1'b1, 1'b1,
      '{7'h7f, 16'hffff, 16'hffff, 16'h0000, 16'hffff, 8'h03}},
    // pair where neither word changed
    '{ROW_WORD, 8'hfe, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_WORD, 8'hff, 16'hffff, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    // pending even word followed by a foreign odd word: dropped
    '{ROW_WORD, 8'h10, 16'h1234, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_WORD, 8'h21, 16'h0001, 1'b1, 1'b0, 1'b1, 1'b1,
      '{7'h10, 16'h0000, 16'h0001, 16'h0000, 16'h0001, 8'h04}},
    '{ROW_WORD, 8'h11, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    // pending even word overtaken by another even word
    '{ROW_WORD, 8'h20, 16'h00ff, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_WORD, 8'h22, 16'hff00, 1'b1, 1'b0, 1'b1, 1'b1,
      '{7'h11, 16'hff00, 16'h0000, 16'hff00, 16'h0000, 8'h05}},
    '{ROW_WORD, 8'h21, 16'h0001, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_WORD, 8'h22, 16'hff00, 1'b1, 1'b0, 1'b0, 1'b0, '0},
    // reporting off: words only stored
    '{ROW_CFG,  8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_WORD, 8'h40, 16'hbeef, 1'b0, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_WORD, 8'h41, 16'hcafe, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_WORD, 8'h50, 16'h0f0f, 1'b0, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_CFG,  8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_WORD, 8'h51, 16'h0001, 1'b1, 1'b0, 1'b1, 1'b1,
      '{7'h28, 16'h0f0f, 16'h0001, 16'h0000, 16'h0001, 8'h06}},
    '{ROW_WORD, 8'h41, 16'hcafe, 1'b1, 1'b0, 1'b0, 1'b0, '0},
    // a word taken while reporting is off drops the pending even word
    '{ROW_WORD, 8'h60, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_WORD, 8'h70, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, '0},
    '{ROW_CFG,  8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, '0},
    '{ROW_WORD, 8'h61, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0, '0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  swcd_in_if  in_ch  ();
  swcd_cfg_if cfg_ch ();
  swcd_out_if rec_ch ();

  status_word_change_detector_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (rec_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state, follows every accepted transfer
  logic [WORD_W-1:0] status_copy [STORE_WORDS] = '{default: '0};
  logic              pend_valid = 1'b0;
  logic [WORD_W-1:0] pend_delta = '0;
  logic [PAIR_W-1:0] pend_pair  = '0;
  logic [SLOT_W-1:0] slot_next  = '0;
  logic              report_on  = 1'b1;

  rec_t records_due [$];
  int   mismatches = 0;
  int   quiet      = 0;

  // handed from the word sender to the checker together with the payload
  logic row_typed = 1'b0;
  logic row_hit   = 1'b0;
  rec_t row_rec   = '0;

  bit calm_links = 1'b0;  // no idling on either side
  bit hold_req   = 1'b0;  // asks the receiver for one long hold-off

  // store the new word; return 1 with the change record when one is due
  function automatic bit derive_change_record(input item_t w, output rec_t r);
    logic [ADDR_W-1:0] idx;
    logic [PAIR_W-1:0] pair;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] even_delta;
    bit                hit;
    idx   = ADDR_W'(w.point_word);
    pair  = w.point_word[POINT_W-1:1];
    delta = w.new_word ^ status_copy[idx];
    status_copy[idx] = w.new_word;
    r   = '0;
    hit = 1'b0;
    if (!report_on) begin
      pend_valid = 1'b0;
      pend_delta = '0;
    end else if (w.point_word[0]) begin
      // odd word closes its pair, pending change only counts for the same pair
      even_delta = (pend_valid && pend_pair == pair) ? pend_delta : '0;
      pend_valid = 1'b0;
      pend_delta = '0;
      hit = (even_delta | delta) != '0;
      r = '{pair, status_copy[{idx[ADDR_W-1:1], 1'b0}], w.new_word, even_delta, delta,
            SLOT_OUT_W'(slot_next)};
    end else begin
      // even word: any older pending word is stale
      pend_valid = 1'b0;
      pend_delta = '0;
      if (!w.last_in_burst) begin
        pend_valid = 1'b1;
        pend_delta = delta;
        pend_pair  = pair;
      end else begin
        hit = delta != '0;
        r = '{pair, w.new_word, status_copy[{idx[ADDR_W-1:1], 1'b1}], delta, '0,
              SLOT_OUT_W'(slot_next)};
      end
    end
    if (hit) slot_next = slot_next + 1'b1;
    return hit;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // biased towards unchanged and single-bit changes so both outcomes are common
  function automatic logic [WORD_W-1:0] pick_word(input logic [POINT_W-1:0] point);
    logic [WORD_W-1:0] held;
    held = status_copy[ADDR_W'(point)];
    case ($urandom_range(0, 9))
      0, 1, 2: return held;
      3, 4:    return held ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1));
      5: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 16'h5555;
          default: return 16'haaaa;
        endcase
      end
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // one status word transfer; a fresh word is chosen only once the store copy is current
  task automatic push_word(input stim_row_t row, input bit fresh);
    int gap;
    gap = calm_links ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (fresh) row.word = pick_word(row.point);
    in_ch.point_word    = row.point;
    in_ch.new_word      = row.word;
    in_ch.last_in_burst = row.last;
    row_typed = row.typed;
    row_hit   = row.hit;
    row_rec   = row.rec;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and let every due record come out, then allow a margin for words in flight
  task automatic settle_records();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_report(input bit on);
    settle_records();
    @(negedge clk);
    cfg_ch.report_changes = on;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin : record_sink
    int stall_left;
    stall_left = 0;
    rec_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        rec_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        rec_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rec_ch.ready = 1'b1;
        stall_left = calm_links ? 0 : pick_gap();
      end
    end
  end

  // checker: records against the oldest expectation, then register and word transfers
  always @(posedge clk) begin : record_check
    rec_t  got;
    rec_t  due;
    item_t w;
    bit    hit;
    if (rst_n) begin
      if (rec_ch.valid && rec_ch.ready) begin
        got = {rec_ch.pair_offset, rec_ch.even_word, rec_ch.odd_word,
               rec_ch.even_change, rec_ch.odd_change, rec_ch.record_slot};
        if (records_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected change record at %0t: pair %h slot %h", $realtime,
                     got.pair_offset, got.record_slot);
        end else begin
          due = records_due.pop_front();
          if (got.pair_offset !== due.pair_offset || got.even_word !== due.even_word ||
              got.odd_word !== due.odd_word || got.even_change !== due.even_change ||
              got.odd_change !== due.odd_change || got.record_slot !== due.record_slot) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"record mismatch at %0t (expected/actual): pair %h/%h even %h/%h",
                        " odd %h/%h even_chg %h/%h odd_chg %h/%h slot %h/%h"}, $realtime,
                       due.pair_offset, got.pair_offset, due.even_word, got.even_word,
                       due.odd_word, got.odd_word, due.even_change, got.even_change,
                       due.odd_change, got.odd_change, due.record_slot, got.record_slot);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) report_on = cfg_ch.report_changes;
      if (in_ch.valid && in_ch.ready) begin
        w   = {in_ch.point_word, in_ch.new_word, in_ch.last_in_burst};
        hit = derive_change_record(w, due);
        // a typed table row overrides the predicted outcome
        if (row_typed) begin
          hit = row_hit;
          due = row_rec;
        end
        if (hit) records_due.push_back(due);
      end
    end
  end

  // watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (rec_ch.valid && rec_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t          row;
    int                 sent;
    int                 len;
    logic [POINT_W-1:0] start;
    bit                 noisy;
    in_ch.valid           = 1'b0;
    in_ch.point_word      = '0;
    in_ch.new_word        = '0;
    in_ch.last_in_burst   = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.report_changes = 1'b1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part: extremes, pairing rules, stale pending words, reporting off
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG)
        write_report(DIRECTED_ROWS[i].report);
      else
        push_word(DIRECTED_ROWS[i], 1'b0);
    end

    // random part: mostly bursts of consecutive words, some stray single words
    for (int phase = 0; phase < PHASES; phase++) begin
      write_report(PHASE_REPORT[phase]);
      calm_links = PHASE_CALM[phase];
      hold_req   = (phase == HOLD_PHASE);
      sent = 0;
      while (sent < PHASE_ITEMS[phase]) begin
        noisy = ($urandom_range(0, 9) >= 8);
        start = POINT_W'($urandom);
        // bursts usually start on a pair boundary
        if (!noisy && $urandom_range(0, 3) != 0) start[0] = 1'b0;
        len = noisy ? 1 : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          row       = '0;
          row.kind  = ROW_WORD;
          row.point = start + POINT_W'(k);
          row.last  = noisy ? 1'($urandom_range(0, 1)) : (k == len - 1);
          push_word(row, 1'b1);
        end
        sent += len;
      end
    end

    settle_records();
    if (mismatches == 0 && records_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
src/swcd_pkg.sv
src/swcd_in_if.sv
src/swcd_cfg_if.sv
src/swcd_out_if.sv
src/swcd_store.sv
src/swcd_pair.sv
src/status_word_change_detector_unit.sv
tb/testbench.sv
